>>> sv/bma_pkg.sv
`timescale 1ns / 1ps

package bma_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned ModW  = 32;
  localparam int unsigned ShW   = 6;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [ModW-1:0] ModulusReset = 32'd4294967291;

  localparam logic [CfgIdxW-1:0] CFG_MODULUS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FACTOR  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FOLD    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SCALAR  = 3'd4;

  typedef enum logic [3:0] {
    FN_MUL           = 4'd0,
    FN_MUL_ADDTO     = 4'd1,
    FN_MUL_SUBTO     = 4'd2,
    FN_SCALE         = 4'd3,
    FN_SCALE_ADDTO   = 4'd4,
    FN_ADD           = 4'd5,
    FN_SUB           = 4'd6,
    FN_NEGATE        = 4'd7,
    FN_ADD_SCALAR    = 4'd8,
    FN_SUB_SCALAR    = 4'd9,
    FN_REDUCE        = 4'd10,
    FN_REDUCE_SIGNED = 4'd11,
    FN_REDUCE_WIDE   = 4'd12
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [DataW-1:0]  a;
    logic [DataW-1:0]  b;
    logic [ModW-1:0]   acc;
    logic              last;
    logic              neg;
  } side_t;

  typedef struct packed {
    side_t             s;
    logic [DataW-1:0]  ra;
  } side2_t;

  function automatic logic [DataW-1:0] min_sub(input logic [DataW-1:0] v,
                                                input logic [ModW-1:0] m);
    logic [DataW-1:0] d;
    d = v - {{(DataW-ModW){1'b0}}, m};
    return (d < v) ? d : v;
  endfunction

  function automatic logic [DataW-1:0] fix_neg(input logic [DataW-1:0] v,
                                                input logic [ModW-1:0] m);
    return v[DataW-1] ? v + {{(DataW-ModW){1'b0}}, m} : v;
  endfunction

endpackage

>>> sv/bma_redc.sv
`timescale 1ns / 1ps

module bma_redc #(
  parameter int unsigned SbW = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [bma_pkg::DataW-1:0] x_i,
  input  logic [SbW-1:0]            side_i,
  input  logic [bma_pkg::ModW-1:0]  modulus_i,
  input  logic [bma_pkg::DataW-1:0] factor_i,
  input  logic [bma_pkg::ShW-1:0]   shift_i,
  output logic                      valid_o,
  output logic [bma_pkg::DataW-1:0] r_o,
  output logic [SbW-1:0]            side_o
);

  localparam int unsigned NStg = 6;

  logic [NStg-1:0] v_q;
  logic [SbW-1:0]  side_q [NStg];

  logic [63:0] x1_q, c1_q, x2_q, lh_q, hl_q, hh_q, x3_q, qh_q, x4_q, p0_q, r5_q, r6_q;
  logic [31:0] p1_q;
  logic [63:0] mid;

  assign mid = hl_q + {32'b0, lh_q[31:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NStg-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 1; i < NStg; i++) begin
        side_q[i] <= side_q[i-1];
      end
      x1_q <= x_i;
      c1_q <= x_i >> shift_i;
      x2_q <= x1_q;
      lh_q <= 64'(c1_q[31:0]) * 64'(factor_i[63:32]);
      hl_q <= 64'(c1_q[63:32]) * 64'(factor_i[31:0]);
      hh_q <= 64'(c1_q[63:32]) * 64'(factor_i[63:32]);
      x3_q <= x2_q;
      qh_q <= hh_q + {32'b0, lh_q[63:32]} + {32'b0, mid[63:32]};
      x4_q <= x3_q;
      p0_q <= 64'(qh_q[31:0]) * 64'(modulus_i);
      p1_q <= 32'(qh_q[63:32] * modulus_i);
      r5_q <= x4_q - (p0_q + {p1_q, 32'b0});
      r6_q <= bma_pkg::min_sub(bma_pkg::min_sub(r5_q, modulus_i), modulus_i);
    end
  end

  assign valid_o = v_q[NStg-1];
  assign r_o     = r6_q;
  assign side_o  = side_q[NStg-1];

endmodule

>>> sv/barrett_modular_alu_32.sv
`timescale 1ns / 1ps

// Channel | Direction | tdata (low bit up)                   | tlast
// s_axis  | in        | func[3:0] opnd_a opnd_b accum_in pad | last_in
// m_axis  | out       | result[31:0]                          | last_out
// cfg     | in        | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// The pipeline has one operand-product stage, two six-stage Barrett
// reducers, one fold-product stage and one result stage.
// A new word is accepted every cycle while the output is not stalled.
// A stalled output word freezes every stage at once; nothing is lost.
// Reset clears all valid bits and loads the register reset values.

module barrett_modular_alu_32 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [167:0]              s_axis_tdata,  // func, opnd_a, opnd_b, accum_in, zeros
  input  logic                      s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata,  // result
  output logic                      m_axis_tlast,
  input  logic                      cfg_we_i,
  input  logic [bma_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bma_pkg::DataW-1:0] cfg_data_i
);

  logic [31:0] modulus_q, fold_q, scalar_q;
  logic [63:0] factor_q;
  logic [5:0]  shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= bma_pkg::ModulusReset;
      factor_q  <= '0;
      shift_q   <= '0;
      fold_q    <= '0;
      scalar_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bma_pkg::CFG_MODULUS: modulus_q <= cfg_data_i[31:0];
        bma_pkg::CFG_FACTOR:  factor_q  <= cfg_data_i;
        bma_pkg::CFG_SHIFT:   shift_q   <= cfg_data_i[5:0];
        bma_pkg::CFG_FOLD:    fold_q    <= cfg_data_i[31:0];
        bma_pkg::CFG_SCALAR:  scalar_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v_q;
  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // Operand stage
  bma_pkg::side_t in_side, t1_side_q;
  logic           t1_v_q;
  logic [63:0]    bop, pp0_q, mag_q, x_a;
  logic [31:0]    pp1_q, pp2_q;

  always_comb begin
    in_side.func = bma_pkg::func_e'(s_axis_tdata[3:0]);
    in_side.a    = s_axis_tdata[67:4];
    in_side.b    = s_axis_tdata[131:68];
    in_side.acc  = s_axis_tdata[163:132];
    in_side.last = s_axis_tlast;
    in_side.neg  = s_axis_tdata[67];
  end

  assign bop = (in_side.func == bma_pkg::FN_SCALE || in_side.func == bma_pkg::FN_SCALE_ADDTO)
             ? {32'b0, scalar_q} : in_side.b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q <= 1'b0;
    end else if (en) begin
      t1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_side_q <= in_side;
      pp0_q     <= 64'(in_side.a[31:0]) * 64'(bop[31:0]);
      pp1_q     <= 32'(in_side.a[31:0] * bop[63:32]);
      pp2_q     <= 32'(in_side.a[63:32] * bop[31:0]);
      mag_q     <= in_side.neg ? (64'd0 - in_side.a) : in_side.a;
    end
  end

  always_comb begin
    case (t1_side_q.func)
      bma_pkg::FN_MUL, bma_pkg::FN_MUL_ADDTO, bma_pkg::FN_MUL_SUBTO,
      bma_pkg::FN_SCALE, bma_pkg::FN_SCALE_ADDTO:
        x_a = pp0_q + {pp1_q + pp2_q, 32'b0};
      bma_pkg::FN_REDUCE_SIGNED: x_a = mag_q;
      default: x_a = t1_side_q.a;
    endcase
  end

  logic           ra_v;
  logic [63:0]    ra;
  bma_pkg::side_t ra_side;

  bma_redc #(.SbW($bits(bma_pkg::side_t))) u_redc_a (
    .clk_i, .rst_ni, .en_i(en), .valid_i(t1_v_q), .x_i(x_a), .side_i(t1_side_q),
    .modulus_i(modulus_q), .factor_i(factor_q), .shift_i(shift_q),
    .valid_o(ra_v), .r_o(ra), .side_o(ra_side)
  );

  // Fold stage for wide reduction
  logic            w_v_q;
  bma_pkg::side2_t w_side_q;
  logic [63:0]     w0_q, x_b;
  logic [31:0]     w1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_v_q <= 1'b0;
    end else if (en) begin
      w_v_q <= ra_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_side_q.s  <= ra_side;
      w_side_q.ra <= ra;
      w0_q        <= 64'(ra[31:0]) * 64'(fold_q);
      w1_q        <= 32'(ra[63:32] * fold_q);
    end
  end

  assign x_b = w0_q + {w1_q, 32'b0} + w_side_q.s.b;

  logic            rb_v;
  logic [63:0]     rb;
  bma_pkg::side2_t rb_side;

  bma_redc #(.SbW($bits(bma_pkg::side2_t))) u_redc_b (
    .clk_i, .rst_ni, .en_i(en), .valid_i(w_v_q), .x_i(x_b), .side_i(w_side_q),
    .modulus_i(modulus_q), .factor_i(factor_q), .shift_i(shift_q),
    .valid_o(rb_v), .r_o(rb), .side_o(rb_side)
  );

  // Result stage
  logic [63:0] r, res, a, b, acc, m, s;
  logic [31:0] res_q;
  logic        last_q;

  always_comb begin
    a   = rb_side.s.a;
    b   = rb_side.s.b;
    acc = {32'b0, rb_side.s.acc};
    m   = {32'b0, modulus_q};
    s   = {32'b0, scalar_q};
    r   = (rb_side.s.func == bma_pkg::FN_REDUCE_WIDE) ? rb : rb_side.ra;
    case (rb_side.s.func)
      bma_pkg::FN_MUL, bma_pkg::FN_SCALE, bma_pkg::FN_REDUCE,
      bma_pkg::FN_REDUCE_WIDE:       res = r;
      bma_pkg::FN_MUL_ADDTO,
      bma_pkg::FN_SCALE_ADDTO:       res = bma_pkg::min_sub(acc + r, modulus_q);
      bma_pkg::FN_MUL_SUBTO:         res = bma_pkg::fix_neg(acc - r, modulus_q);
      bma_pkg::FN_ADD:               res = bma_pkg::min_sub(a + b, modulus_q);
      bma_pkg::FN_SUB:               res = bma_pkg::fix_neg(a - b, modulus_q);
      bma_pkg::FN_NEGATE:            res = (a == 64'd0) ? 64'd0 : m - a;
      bma_pkg::FN_ADD_SCALAR:        res = bma_pkg::min_sub(a + s, modulus_q);
      bma_pkg::FN_SUB_SCALAR:        res = bma_pkg::fix_neg(a - s, modulus_q);
      bma_pkg::FN_REDUCE_SIGNED:     res = (rb_side.s.neg && r != 64'd0) ? m - r : r;
      default:                       res = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= rb_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res[31:0];
      last_q <= rb_side.s.last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tlast  = last_q;

endmodule

>>> sv/bma_chk.sv
`timescale 1ns / 1ps

module bma_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  a_ready_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input not ready while output drains");

endmodule

bind barrett_modular_alu_32 bma_chk u_bma_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tlast(m_axis_tlast)
);
